/* hdl/particle_to_grid_scatter_macros.svh */
// assertion macros for the particle to grid scatter block
`ifndef PARTICLE_TO_GRID_SCATTER_MACROS_SVH
`define PARTICLE_TO_GRID_SCATTER_MACROS_SVH
// implication checked on every clock edge outside reset
`define P2G_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next cycle implication checked outside reset
`define P2G_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

/* hdl/p2g_pkg.sv */
// shared types and constants for the particle to grid scatter block
`default_nettype none
package p2g_pkg;
  localparam int FB = 16;
  localparam int W_Q = 2 * FB;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_SCATTER = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_INV_X    = 3'd2,
    REG_INV_Y    = 3'd3,
    REG_NODES_X  = 3'd4,
    REG_NODES_Y  = 3'd5,
    REG_BOUNDARY = 3'd6
  } reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_LOC, S_WGT, S_CHK, S_SHARE, S_MOM, S_RD, S_ACC, S_WR,
    S_DONE_SC, S_RREAD, S_RWAIT, S_DIV, S_DONE_RD, S_DONE_NIL, S_INIT
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0] particle_mass;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [5:0]  node_col;
    logic [5:0]  node_row;
  } req_t;

  typedef struct packed {
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic [16:0] weight_00;
    logic [16:0] weight_10;
    logic [16:0] weight_11;
    logic [16:0] weight_01;
    logic        out_of_grid;
    logic [46:0] node_mass_out;
    logic signed [31:0] node_vel_x;
    logic signed [31:0] node_vel_y;
    logic        node_has_mass;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clr_step;
    logic loc;
    logic wgt;
    logic share;
    logic mom;
    logic rd;
    logic acc;
    logic wr;
    logic next_node;
    logic rread;
    logic div_start;
    logic out_sc;
    logic out_rd;
    logic out_nil;
  } cmd_t;

  // datapath status
  typedef struct packed {
    logic clr_last;
    logic oog;
    logic last_node;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

/* hdl/p2g_ram.sv */
// generic single port ram with registered read
`default_nettype none
module p2g_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] addr,
  input  wire [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  // read first port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* hdl/p2g_div.sv */
// restoring divider: momentum * 2^F / mass, saturated to 32 bits
`default_nettype none
module p2g_div #(
  parameter int FRAC = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire signed [47:0] mom,
  input  wire [47:0]        mass,
  output logic              done,
  output logic signed [31:0] q
);
  localparam int STEPS = 48 + FRAC;
  localparam int CW = $clog2(STEPS + 1);
  logic          busy;
  logic [CW-1:0] cnt;
  logic [STEPS-1:0] num;
  logic [48:0]   rem;
  logic [STEPS-1:0] quo;
  logic          neg;
  logic          zero;
  logic [48:0]   trial;
  logic [48:0]   shifted;
  logic [STEPS-1:0] mag;

  assign shifted = {rem[47:0], num[STEPS-1]};
  assign trial = shifted - {1'b0, mass};
  assign mag = {(mom[47] ? 48'(-mom) : 48'(mom)), {FRAC{1'b0}}};

  // one quotient bit per cycle while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= (mass != 48'd0);
        done <= (mass == 48'd0);
      end else if (busy && cnt == CW'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      cnt <= '0;
      num <= mag;
      rem <= '0;
      quo <= '0;
      neg <= mom[47];
      zero <= (mass == 48'd0);
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      num <= {num[STEPS-2:0], 1'b0};
      if (!trial[48]) begin
        rem <= trial;
        quo <= {quo[STEPS-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[STEPS-2:0], 1'b0};
      end
    end
  end

  // saturate the magnitude and apply the sign; a zero mass gives zero
  always_comb begin
    if (zero) begin
      q = '0;
    end else if (neg) begin
      q = (quo > STEPS'(64'h80000000)) ? 32'sh80000000 : -$signed(quo[31:0]);
    end else begin
      q = (quo > STEPS'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(quo[31:0]);
    end
  end
endmodule
`default_nettype wire

/* hdl/p2g_datapath.sv */
// datapath: locate, weights, node store update and read
`default_nettype none
module p2g_datapath #(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64
) (
  input  wire               clk,
  input  wire               rst,
  input  p2g_pkg::cmd_t     cmd,
  output p2g_pkg::sts_t     sts,
  input  p2g_pkg::req_t     req,
  input  wire               cfg_we,
  input  wire [2:0]         cfg_idx,
  input  wire [31:0]        cfg_data,
  output p2g_pkg::rsp_t     rsp
);
  import p2g_pkg::*;
  localparam int CXW = $clog2(GRID_X);
  localparam int CYW = $clog2(GRID_Y);
  localparam int AW = CXW + CYW;
  localparam int DEPTH = GRID_X * GRID_Y;
  localparam logic [47:0] MAXP = 48'h7FFFFFFFFFFF;
  localparam logic [47:0] MINP = 48'h800000000000;

  // configuration registers
  logic signed [31:0] origin_x, origin_y;
  logic [30:0] inv_x, inv_y;
  logic [6:0]  nodes_x, nodes_y;
  logic [3:0]  bmask;
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      inv_x <= 31'd65536;
      inv_y <= 31'd65536;
      nodes_x <= 7'd64;
      nodes_y <= 7'd64;
      bmask <= '0;
    end else if (cfg_we) begin
      case (reg_t'(cfg_idx))
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_INV_X:    inv_x <= cfg_data[30:0];
        REG_INV_Y:    inv_y <= cfg_data[30:0];
        REG_NODES_X:  nodes_x <= cfg_data[6:0];
        REG_NODES_Y:  nodes_y <= cfg_data[6:0];
        REG_BOUNDARY: bmask <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamped node counts
  logic [10:0] nx, ny;
  always_comb begin
    nx = (nodes_x < 7'd2) ? 11'd2 : ({4'd0, nodes_x} > 11'(GRID_X) ? 11'(GRID_X)
                                     : {4'd0, nodes_x});
    ny = (nodes_y < 7'd2) ? 11'd2 : ({4'd0, nodes_y} > 11'(GRID_Y) ? 11'(GRID_Y)
                                     : {4'd0, nodes_y});
  end

  // request capture
  req_t r;
  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
  end

  // offset and cell products
  logic signed [32:0] dx, dy;
  logic [63:0] tx, ty;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx <= 33'(req.pos_x) - 33'(origin_x);
      dy <= 33'(req.pos_y) - 33'(origin_y);
    end
    if (cmd.loc) begin
      tx <= 64'(dx[31:0]) * 64'(inv_x);
      ty <= 64'(dy[31:0]) * 64'(inv_y);
    end
  end

  // fractions, cell, weights
  logic [15:0] wx, wy;
  logic [16:0] w00, w10, w11, w01;
  logic [31:0] cx, cy;
  logic        oog;
  assign wx = tx[31:16];
  assign wy = ty[31:16];
  assign cx = tx[63:32];
  assign cy = ty[63:32];
  always_ff @(posedge clk) begin
    if (cmd.wgt) begin
      w00 <= 17'((34'(17'h10000 - wx) * 34'(17'h10000 - wy)) >> 16);
      w10 <= 17'((34'(wx) * 34'(17'h10000 - wy)) >> 16);
      w11 <= 17'((34'(wx) * 34'(wy)) >> 16);
      w01 <= 17'((34'(17'h10000 - wx) * 34'(wy)) >> 16);
      oog <= dx[32] || dy[32] || (cx > 32'(nx - 11'd2)) || (cy > 32'(ny - 11'd2));
    end
  end
  assign sts.oog = oog;

  // node walk over four corners
  logic [1:0]  corner;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] addr;
  logic [16:0] wsel;
  logic [CXW-1:0] ncol;
  logic [CYW-1:0] nrow;
  always_comb begin
    ncol = cx[CXW-1:0] + CXW'(corner == 2'd1 || corner == 2'd2);
    nrow = cy[CYW-1:0] + CYW'(corner[1]);
    case (corner)
      2'd0: wsel = w00;
      2'd1: wsel = w10;
      2'd2: wsel = w11;
      default: wsel = w01;
    endcase
  end
  assign sts.last_node = (corner == 2'd3);
  assign sts.clr_last = (clr_addr == AW'(DEPTH - 1));
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      corner <= '0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.load) corner <= '0;
      else if (cmd.next_node) corner <= corner + 1'b1;
    end
  end

  // share and momentum shares
  logic [30:0] share;
  logic signed [47:0] mx, my;
  logic signed [63:0] px, py;
  always_ff @(posedge clk) begin
    if (cmd.share) share <= 31'((64'(r.particle_mass) * 64'(wsel)) >> 16);
    if (cmd.mom) begin
      px <= $signed({1'b0, share}) * r.vel_x;
      py <= $signed({1'b0, share}) * r.vel_y;
    end
  end
  assign mx = 48'(px >>> 16);
  assign my = 48'(py >>> 16);

  // node store
  logic        we;
  logic [47:0] m_rd, x_rd, y_rd;
  logic        f_rd;
  logic [47:0] m_wd, x_wd, y_wd;
  logic        f_wd;
  logic [CXW-1:0] rcol;
  logic [CYW-1:0] rrow;
  assign rcol = r.node_col[CXW-1:0];
  assign rrow = r.node_row[CYW-1:0];
  // read address held for the whole read request
  always_comb begin
    if (cmd.clr_step) addr = clr_addr;
    else if (cmd.rread || op_t'(r.op) == OP_READ) addr = {rrow, rcol};
    else addr = {nrow, ncol};
  end
  assign we = cmd.clr_step || cmd.wr;

  p2g_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_mass (
    .clk(clk), .we(we), .addr(addr), .wdata(m_wd), .rdata(m_rd));
  p2g_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_momx (
    .clk(clk), .we(we), .addr(addr), .wdata(x_wd), .rdata(x_rd));
  p2g_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_momy (
    .clk(clk), .we(we), .addr(addr), .wdata(y_wd), .rdata(y_rd));
  p2g_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_flag (
    .clk(clk), .we(we), .addr(addr), .wdata(f_wd), .rdata(f_rd));

  // saturating accumulate
  logic [47:0] acc_m, acc_x, acc_y;
  logic [48:0] sm;
  logic signed [48:0] sx, sy;
  always_comb begin
    sm = {1'b0, m_rd} + 49'(share);
    sx = 49'(signed'(x_rd)) + 49'(mx);
    sy = 49'(signed'(y_rd)) + 49'(my);
  end
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      acc_m <= (sm > 49'(MAXP)) ? MAXP : sm[47:0];
      acc_x <= (sx > 49'(signed'(MAXP))) ? MAXP :
               (sx < 49'(signed'(MINP))) ? MINP : sx[47:0];
      acc_y <= (sy > 49'(signed'(MAXP))) ? MAXP :
               (sy < 49'(signed'(MINP))) ? MINP : sy[47:0];
    end
  end
  always_comb begin
    m_wd = cmd.clr_step ? '0 : acc_m;
    x_wd = cmd.clr_step ? '0 : acc_x;
    y_wd = cmd.clr_step ? '0 : acc_y;
    f_wd = !cmd.clr_step;
  end

  // shared divider, y then x; the x pass starts as the y pass ends
  logic        div_done, dsel;
  logic        div_go;
  logic signed [31:0] dq;
  logic signed [31:0] qx;
  assign div_go = cmd.div_start || (div_done && !dsel);
  p2g_div #(.FRAC(FB)) u_div (
    .clk(clk), .rst(rst), .start(div_go),
    .mom(cmd.div_start ? y_rd : x_rd), .mass(m_rd), .done(div_done), .q(dq));
  always_ff @(posedge clk) begin
    if (rst) dsel <= 1'b0;
    else if (cmd.rread) dsel <= 1'b0;
    else if (div_done) dsel <= ~dsel;
  end
  logic signed [31:0] qy;
  always_ff @(posedge clk) begin
    if (div_done && !dsel) qy <= dq;
    if (div_done && dsel) qx <= dq;
  end
  assign sts.div_done = div_done && dsel;

  // boundary rules and result
  logic        in_store;
  logic signed [31:0] bvx, bvy;
  rsp_t        rsp_next;
  assign in_store = (32'(r.node_col) < 32'(GRID_X)) && (32'(r.node_row) < 32'(GRID_Y));
  always_comb begin
    bvx = dq;
    bvy = qy;
    if ((bmask[0] && r.node_col == 6'd0) || (bmask[1] && r.node_row == 6'd0) ||
        (bmask[2] && 11'(r.node_col) == nx - 11'd1)) begin
      bvx = '0;
      bvy = '0;
    end
    if (bmask[3] && 11'(r.node_row) == ny - 11'd1) begin
      bvx = dq;
      bvy = '0;
    end
  end
  always_comb begin
    rsp_next = '0;
    if (cmd.out_sc && !oog) begin
      rsp_next.cell_col = cx[5:0];
      rsp_next.cell_row = cy[5:0];
      rsp_next.weight_00 = w00;
      rsp_next.weight_10 = w10;
      rsp_next.weight_11 = w11;
      rsp_next.weight_01 = w01;
    end else if (cmd.out_sc) begin
      rsp_next.out_of_grid = 1'b1;
    end else if (cmd.out_rd && in_store) begin
      rsp_next.node_mass_out = m_rd[46:0];
      rsp_next.node_vel_x = bvx;
      rsp_next.node_vel_y = bvy;
      rsp_next.node_has_mass = f_rd;
    end
  end
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end
  logic unused;
  assign unused = ^{qx, cmd.out_nil, cmd.rd};
endmodule
`default_nettype wire

/* hdl/p2g_ctrl.sv */
// controller state machine for the scatter block
`default_nettype none
`include "particle_to_grid_scatter_macros.svh"
module p2g_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  input  wire [1:0]      op,
  output logic           busy,
  output logic           done,
  output p2g_pkg::cmd_t  cmd,
  input  p2g_pkg::sts_t  sts
);
  import p2g_pkg::*;
  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      // clearing pass after reset, no result
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          case (op_t'(op))
            OP_CLEAR:   state_next = S_CLEAR;
            OP_SCATTER: state_next = S_LOC;
            OP_READ:    state_next = S_RREAD;
            default:    state_next = S_DONE_NIL;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_DONE_NIL;
      end
      S_LOC: begin cmd.loc = 1'b1; state_next = S_WGT; end
      S_WGT: begin cmd.wgt = 1'b1; state_next = S_CHK; end
      S_CHK: state_next = sts.oog ? S_DONE_SC : S_SHARE;
      S_SHARE: begin cmd.share = 1'b1; state_next = S_MOM; end
      S_MOM: begin cmd.mom = 1'b1; state_next = S_RD; end
      S_RD: begin cmd.rd = 1'b1; state_next = S_ACC; end
      S_ACC: begin cmd.acc = 1'b1; state_next = S_WR; end
      S_WR: begin
        cmd.wr = 1'b1;
        cmd.next_node = 1'b1;
        state_next = sts.last_node ? S_DONE_SC : S_SHARE;
      end
      S_DONE_SC: begin cmd.out_sc = 1'b1; state_next = S_IDLE; end
      S_RREAD: begin cmd.rread = 1'b1; state_next = S_RWAIT; end
      S_RWAIT: begin cmd.div_start = 1'b1; state_next = S_DIV; end
      S_DIV: begin
        if (sts.div_done) state_next = S_DONE_RD;
      end
      S_DONE_RD: begin cmd.out_rd = 1'b1; state_next = S_IDLE; end
      S_DONE_NIL: begin cmd.out_nil = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  // result strobe registered from the output command, in the cycle after it
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.out_sc || cmd.out_rd || cmd.out_nil;
  end

  `P2G_ASSERT_NEXT(a_done_after_out, clk, rst, cmd.out_sc || cmd.out_rd || cmd.out_nil, done, "result strobe missing")
  `P2G_ASSERT_IMP(a_no_start_busy, clk, rst, busy, !cmd.load, "request taken while busy")
  `P2G_ASSERT_IMP(a_wr_not_clear, clk, rst, cmd.wr, !cmd.clr_step, "clear and scatter write together")
  `P2G_ASSERT_IMP(a_idle_quiet, clk, rst, !busy, !cmd.wr, "store write while idle")
endmodule
`default_nettype wire

/* hdl/particle_to_grid_scatter.sv */
// top level of the particle to grid scatter block
//
// Requests enter on req when start is high and busy is low; op selects
// clear, scatter or read, and op 3 does nothing. Each request gives one
// result on rsp, marked by a one cycle done strobe; the receiver cannot
// stall, so it must take rsp in that cycle. Busy is already low in the
// cycle with done high, so the next request can be taken there.
// Scatter: locate and weigh, then for each corner node the read,
// accumulate and write over the single port node store, then finish.
// An out of grid scatter skips the corner nodes.
// Read: the bit serial divider computes both velocity components one
// after the other.
// Clear: every node of the store is cleared in turn.
// After reset the block runs the same clearing pass over the node store
// with busy high and gives no result; configuration writes on
// cfg_we/cfg_idx/cfg_data are taken at any time and must only be
// made while the block is idle.
`default_nettype none
module particle_to_grid_scatter #(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  output logic           busy,
  input  p2g_pkg::req_t  req,
  output logic           done,
  output p2g_pkg::rsp_t  rsp,
  input  wire            cfg_we,
  input  wire [2:0]      cfg_idx,
  input  wire [31:0]     cfg_data
);
  import p2g_pkg::*;
  cmd_t cmd;
  sts_t sts;

  p2g_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(req.op),
    .busy(busy), .done(done), .cmd(cmd), .sts(sts));

  p2g_datapath #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .req(req),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .rsp(rsp));
endmodule
`default_nettype wire
